// File: rtl/i2cmbs_pkg.sv
// ----------------------------------------------------------------------------
// I2C master bit sequencer package
// Command codes, field widths and register defaults shared by the sequencer.
// ----------------------------------------------------------------------------
package i2cmbs_pkg;

    localparam int UNIT_W     = 16;
    localparam int BYTE_W     = 8;
    localparam int STEP_W     = 5;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;

    localparam logic [UNIT_W-1:0] UNIT_TICKS_RST = 16'd72;

    // delay units at which the longer commands reach their last phases
    localparam logic [STEP_W-1:0] WR_STEP_RELEASE = 5'd24;
    localparam logic [STEP_W-1:0] WR_STEP_DONE    = 5'd25;
    localparam logic [STEP_W-1:0] RD_STEP_DONE    = 5'd16;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4,
        CMD_WACK  = 3'd5,
        CMD_ACK   = 3'd6,
        CMD_NACK  = 3'd7
    } cmd_t;

    // position of a delay unit within a write bit slot
    typedef enum logic [1:0] {
        SLOT_DATA = 2'd0,
        SLOT_HIGH = 2'd1,
        SLOT_LOW  = 2'd2
    } slot_t;

endpackage

// File: rtl/i2c_master_bit_sequencer_unit.sv
// Path: an input transaction is held in the input register, then its result in the result register.
// Throughput: one transaction per cycle while the master side does not stall, set by the
// single-pass update of the sequencer state between the input register and the result register.
// Reset: asynchronous, active low; bus released (SCL 1, SDA 1), sequencer idle,
// unit_ticks back to 72.
// ----------------------------------------------------------------------------
// I2C master bit sequencer
// Steps SCL and open-drain SDA through start, stop, byte and ack phases, one
// clock tick per input transaction, with a configurable delay unit length.
// ----------------------------------------------------------------------------
module i2c_master_bit_sequencer_unit (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_wr_en,
    input  logic [i2cmbs_pkg::UNIT_W-1:0]       cfg_wr_data,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [2:0] action, [10:3] byte_in, [11] sda_in, [15:12] zero
    input  logic [i2cmbs_pkg::IN_DATA_W-1:0]    s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] nack_seen, [15:13] zero
    output logic [i2cmbs_pkg::OUT_DATA_W-1:0]   m_tdata
);
    import i2cmbs_pkg::*;

    logic                  in_valid_reg;
    logic [IN_DATA_W-1:0]  in_data_reg;
    logic                  m_tvalid_reg;
    logic                  m_tvalid_next;
    logic [OUT_DATA_W-1:0] m_tdata_reg;
    logic [OUT_DATA_W-1:0] m_tdata_next;
    logic                  advance;

    logic [UNIT_W-1:0]     unit_ticks_reg;
    cmd_t                  cmd_reg,   cmd_next;
    logic [STEP_W-1:0]     step_reg,  step_next;
    slot_t                 slot_reg,  slot_next;
    logic [UNIT_W-1:0]     tick_reg,  tick_next;
    logic [BYTE_W-1:0]     shift_reg, shift_next;
    logic                  scl_reg,   scl_next;
    logic                  sda_reg,   sda_next;
    logic [BYTE_W-1:0]     rdata_reg, rdata_next;
    logic                  nack_reg,  nack_next;

    logic [2:0]            action;
    logic [BYTE_W-1:0]     byte_in;
    logic                  sda_in;
    logic [UNIT_W-1:0]     limit;
    logic [UNIT_W-1:0]     tick_inc;
    logic [STEP_W-1:0]     k;
    logic                  fin;
    logic                  done;

    assign action  = in_data_reg[2:0];
    assign byte_in = in_data_reg[10:3];
    assign sda_in  = in_data_reg[11];

    assign advance  = in_valid_reg && (!m_tvalid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    always_comb
    begin
        cmd_next   = cmd_reg;
        step_next  = step_reg;
        slot_next  = slot_reg;
        tick_next  = tick_reg;
        shift_next = shift_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        rdata_next = rdata_reg;
        nack_next  = nack_reg;
        done       = 1'b0;
        fin        = 1'b0;
        limit      = (unit_ticks_reg == '0) ? UNIT_W'(1) : unit_ticks_reg;
        tick_inc   = tick_reg + UNIT_W'(1);
        k          = step_reg + STEP_W'(1);

        if (cmd_reg != CMD_NONE)
        begin
            if (tick_inc >= limit)
            begin
                tick_next = '0;
                step_next = k;
                case (slot_reg)
                    SLOT_DATA: slot_next = SLOT_HIGH;
                    SLOT_HIGH: slot_next = SLOT_LOW;
                    default:   slot_next = SLOT_DATA;
                endcase
                case (cmd_reg)
                    CMD_START:
                    begin
                        if (k == STEP_W'(1))
                            sda_next = 1'b0;
                        else
                            fin = 1'b1;
                    end
                    CMD_STOP:
                    begin
                        sda_next = 1'b1;
                        fin      = 1'b1;
                    end
                    CMD_WRITE:
                    begin
                        if (k >= WR_STEP_DONE)
                            fin = 1'b1;
                        else if (k == WR_STEP_RELEASE)
                            sda_next = 1'b1;
                        else if (slot_next == SLOT_HIGH)
                            scl_next = 1'b1;
                        else if (slot_next == SLOT_LOW)
                        begin
                            scl_next   = 1'b0;
                            shift_next = {shift_reg[BYTE_W-2:0], 1'b0};
                        end
                        else
                            sda_next = shift_reg[BYTE_W-1];
                    end
                    CMD_READ:
                    begin
                        if (k[0])
                        begin
                            shift_next = {shift_reg[BYTE_W-2:0], sda_in};
                            scl_next   = 1'b0;
                        end
                        else if (k < RD_STEP_DONE)
                            scl_next = 1'b1;
                        else
                        begin
                            rdata_next = shift_reg;
                            fin        = 1'b1;
                        end
                    end
                    CMD_WACK, CMD_ACK, CMD_NACK:
                    begin
                        if (k == STEP_W'(1))
                            scl_next = 1'b1;
                        else if (k == STEP_W'(2))
                        begin
                            if (cmd_reg == CMD_WACK)
                                nack_next = sda_in;
                            scl_next = 1'b0;
                        end
                        else
                        begin
                            if (cmd_reg == CMD_ACK)
                                sda_next = 1'b1;
                            fin = 1'b1;
                        end
                    end
                    default:
                        fin = 1'b1;
                endcase
                if (fin)
                begin
                    cmd_next  = CMD_NONE;
                    step_next = '0;
                    done      = 1'b1;
                end
            end
            else
                tick_next = tick_inc;
        end
        else if (action != CMD_NONE)
        begin
            cmd_next  = cmd_t'(action);
            step_next = '0;
            slot_next = SLOT_DATA;
            tick_next = '0;
            case (cmd_t'(action))
                CMD_START:
                begin
                    sda_next = 1'b1;
                    scl_next = 1'b1;
                end
                CMD_STOP:
                begin
                    sda_next = 1'b0;
                    scl_next = 1'b1;
                end
                CMD_WRITE:
                begin
                    shift_next = byte_in;
                    scl_next   = 1'b0;
                    sda_next   = byte_in[BYTE_W-1];
                end
                CMD_READ:
                begin
                    shift_next = '0;
                    scl_next   = 1'b1;
                end
                CMD_ACK:
                    sda_next = 1'b0;
                default:
                    sda_next = 1'b1;
            endcase
        end

        m_tdata_next = {3'b000, nack_next, rdata_next, done,
                        (cmd_next != CMD_NONE), sda_next, scl_next};
    end

    always_comb
    begin
        if (advance)
            m_tvalid_next = 1'b1;
        else if (m_tready)
            m_tvalid_next = 1'b0;
        else
            m_tvalid_next = m_tvalid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            m_tvalid_reg   <= 1'b0;
            unit_ticks_reg <= UNIT_TICKS_RST;
            cmd_reg        <= CMD_NONE;
            step_reg       <= '0;
            slot_reg       <= SLOT_DATA;
            tick_reg       <= '0;
            shift_reg      <= '0;
            scl_reg        <= 1'b1;
            sda_reg        <= 1'b1;
            rdata_reg      <= '0;
            nack_reg       <= 1'b0;
        end
        else
        begin
            if (s_tready)
                in_valid_reg <= s_tvalid;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_wr_en)
                unit_ticks_reg <= cfg_wr_data;
            if (advance)
            begin
                cmd_reg   <= cmd_next;
                step_reg  <= step_next;
                slot_reg  <= slot_next;
                tick_reg  <= tick_next;
                shift_reg <= shift_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
                rdata_reg <= rdata_next;
                nack_reg  <= nack_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
            in_data_reg <= s_tdata;
        if (advance)
            m_tdata_reg <= m_tdata_next;
    end

endmodule

// File: dv/tb_i2c_master_bit_sequencer_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// I2C master bit sequencer testbench
// Streams clock ticks into the sequencer, each tick carrying an optional
// command, a byte and a sampled SDA level. A scoreboard steps its own copy of
// the sequencer on every accepted tick and checks the SCL, SDA, busy, done,
// read byte and nack fields of every result, in order. The delay unit length
// runs through the reset value, zero, one, small values and the maximum.
// ----------------------------------------------------------------------------
module tb_i2c_master_bit_sequencer_unit;

    import i2cmbs_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    typedef struct packed {
        logic       nack;
        logic [7:0] rd_byte;
        logic       done;
        logic       busy;
        logic       sda;
        logic       scl;
    } pin_result_t;

    class i2c_seq_checker;
        logic [15:0] unit_ticks;
        cmd_t        cur_cmd;
        logic [4:0]  step;
        logic [15:0] tick_cnt;
        logic [7:0]  shreg;
        logic        scl;
        logic        sda;
        logic [7:0]  rx_byte;
        logic        nack;
        pin_result_t pin_expect_q[$];
        int          errors;
        int          ticks;
        int          cmds_started;
        int          cmds_done;

        function new();
            unit_ticks   = UNIT_TICKS_RST;
            cur_cmd      = CMD_NONE;
            step         = '0;
            tick_cnt     = '0;
            shreg        = '0;
            scl          = 1'b1;
            sda          = 1'b1;
            rx_byte      = '0;
            nack         = 1'b0;
            errors       = 0;
            ticks        = 0;
            cmds_started = 0;
            cmds_done    = 0;
        endfunction

        // pin actions after k completed delay units; returns 1 when finished
        function bit apply_phase(logic [4:0] k, logic s);
            case (cur_cmd)
                CMD_START:
                begin
                    if (k == 0)
                    begin
                        sda = 1'b1;
                        scl = 1'b1;
                    end
                    else if (k == 1)
                        sda = 1'b0;
                    else
                        return 1'b1;
                    return 1'b0;
                end
                CMD_STOP:
                begin
                    if (k == 0)
                    begin
                        sda = 1'b0;
                        scl = 1'b1;
                        return 1'b0;
                    end
                    sda = 1'b1;
                    return 1'b1;
                end
                CMD_WRITE:
                begin
                    if (k == 0)
                    begin
                        scl = 1'b0;
                        sda = shreg[7];
                    end
                    else if (k >= WR_STEP_DONE)
                        return 1'b1;
                    else if (k == WR_STEP_RELEASE)
                        sda = 1'b1;
                    else if (k % 3 == 1)
                        scl = 1'b1;
                    else if (k % 3 == 2)
                    begin
                        scl   = 1'b0;
                        shreg = shreg << 1;
                    end
                    else
                        sda = shreg[7];
                    return 1'b0;
                end
                CMD_READ:
                begin
                    if (k == 0)
                    begin
                        shreg = '0;
                        scl   = 1'b1;
                    end
                    else if (k[0])
                    begin
                        shreg = {shreg[6:0], s};
                        scl   = 1'b0;
                    end
                    else if (k < RD_STEP_DONE)
                        scl = 1'b1;
                    else
                    begin
                        rx_byte = shreg;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                CMD_WACK, CMD_ACK, CMD_NACK:
                begin
                    if (k == 0)
                        sda = (cur_cmd == CMD_ACK) ? 1'b0 : 1'b1;
                    else if (k == 1)
                        scl = 1'b1;
                    else if (k == 2)
                    begin
                        if (cur_cmd == CMD_WACK)
                            nack = s;
                        scl = 1'b0;
                    end
                    else
                    begin
                        if (cur_cmd == CMD_ACK)
                            sda = 1'b1;
                        return 1'b1;
                    end
                    return 1'b0;
                end
                default:
                    return 1'b1;
            endcase
        endfunction

        function void log_tick(logic [15:0] d);
            cmd_t        act;
            logic        s;
            logic        done;
            logic [15:0] lim;
            pin_result_t r;
            act  = cmd_t'(d[2:0]);
            s    = d[11];
            done = 1'b0;
            if (cur_cmd != CMD_NONE)
            begin
                lim      = (unit_ticks == 0) ? 16'd1 : unit_ticks;
                tick_cnt = tick_cnt + 16'd1;
                if (tick_cnt >= lim)
                begin
                    tick_cnt = '0;
                    step     = step + 5'd1;
                    if (apply_phase(step, s))
                    begin
                        cur_cmd = CMD_NONE;
                        step    = '0;
                        done    = 1'b1;
                        cmds_done++;
                    end
                end
            end
            else if (act != CMD_NONE)
            begin
                cur_cmd  = act;
                step     = '0;
                tick_cnt = '0;
                if (act == CMD_WRITE)
                    shreg = d[10:3];
                void'(apply_phase(5'd0, s));
                cmds_started++;
            end
            r.nack    = nack;
            r.rd_byte = rx_byte;
            r.done    = done;
            r.busy    = (cur_cmd != CMD_NONE);
            r.sda     = sda;
            r.scl     = scl;
            pin_expect_q.push_back(r);
            ticks++;
        endfunction

        function void check_pins(logic [15:0] d);
            pin_result_t want;
            pin_result_t got;
            got = pin_result_t'(d[12:0]);
            if (pin_expect_q.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("[%0t] result %h with no tick pending", $time, d);
            end
            else
            begin
                want = pin_expect_q.pop_front();
                if (got !== want || d[15:13] !== 3'b000)
                begin
                    errors++;
                    if (errors <= 10)
                        $display({"[%0t] exp scl %b sda %b busy %b done %b rd %h nack %b",
                                  " | got scl %b sda %b busy %b done %b rd %h nack %b pad %b"},
                                 $time, want.scl, want.sda, want.busy, want.done,
                                 want.rd_byte, want.nack, got.scl, got.sda, got.busy,
                                 got.done, got.rd_byte, got.nack, d[15:13]);
                end
            end
        endfunction

        function int pending();
            return pin_expect_q.size();
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        cfg_wr_en;
    logic [15:0] cfg_wr_data;
    logic        s_tvalid;
    logic        s_tready;
    // [2:0] action, [10:3] byte_in, [11] sda_in, [15:12] zero
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    // [0] scl_out, [1] sda_out, [2] busy_res, [3] done_res, [11:4] read_data,
    // [12] nack_seen, [15:13] zero
    logic [15:0] m_tdata;

    i2c_seq_checker sb;
    logic [15:0]    unit_cfg;
    int             burst_left;
    int             idle_cycles;
    int             unit_settings;
    logic [9:0]     rx_cyc;

    i2c_master_bit_sequencer_unit dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // receiver: free flow, random stalls, a periodic stall, then random stalls again, in turn
    always @(posedge clk)
    begin
        rx_cyc <= rx_cyc + 10'd1;
        case (rx_cyc[9:8])
            2'd0: m_tready <= 1'b1;
            2'd1: m_tready <= ($urandom_range(0, 2) != 0);
            2'd2: m_tready <= (rx_cyc[2:0] != 3'd5);
            default: m_tready <= ($urandom_range(0, 7) > 1);
        endcase
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
                sb.check_pins(m_tdata);
            if (s_tvalid && s_tready)
                sb.log_tick(s_tdata);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || !rst_n)
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("[%0t] no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("Mismatches found");
            $finish;
        end
    end

    task automatic send_tick(input cmd_t act, input logic [7:0] data_byte, input logic s);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {4'b0000, s, data_byte, act};
        do
            @(posedge clk);
        while (!s_tready);
        burst_left--;
        if (burst_left <= 0)
        begin
            burst_left = $urandom_range(1, 40);
            gap        = $urandom_range(0, 4);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    // sda_mode: 0 hold low, 1 hold high, 2 random per tick
    task automatic issue_command(input cmd_t c, input logic [7:0] data_byte,
                                 input int sda_mode, input bit noisy);
        int units;
        int busy_ticks;
        case (c)
            CMD_NONE:  units = 0;
            CMD_START: units = 2;
            CMD_STOP:  units = 1;
            CMD_WRITE: units = WR_STEP_DONE;
            CMD_READ:  units = RD_STEP_DONE;
            default:   units = 3;
        endcase
        busy_ticks = units * ((unit_cfg == 0) ? 1 : int'(unit_cfg));
        send_tick(c, data_byte, (sda_mode == 2) ? 1'($urandom_range(0, 1)) : sda_mode[0]);
        for (int i = 0; i < busy_ticks; i++)
            send_tick(noisy ? cmd_t'($urandom_range(1, 7)) : cmd_t'($urandom_range(0, 7)),
                      8'($urandom_range(0, 255)),
                      (sda_mode == 2) ? 1'($urandom_range(0, 1)) : sda_mode[0]);
    endtask

    task automatic set_unit(input logic [15:0] v);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= v;
        @(posedge clk);
        cfg_wr_en     <= 1'b0;
        sb.unit_ticks = v;
        unit_cfg      = v;
        unit_settings++;
    endtask

    task automatic run_random(input int n);
        int stop_at;
        stop_at = sb.ticks + n;
        while (sb.ticks < stop_at)
        begin
            if ($urandom_range(0, 9) == 0)
                issue_command(CMD_NONE, 8'($urandom_range(0, 255)), 2, 1'b0);
            else
                issue_command(cmd_t'($urandom_range(1, 7)), 8'($urandom_range(0, 255)),
                              2, 1'b0);
        end
    endtask

    initial
    begin
        sb            = new();
        unit_cfg      = UNIT_TICKS_RST;
        burst_left    = 20;
        idle_cycles   = 0;
        unit_settings = 1;
        rx_cyc        = '0;
        rst_n       <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_wr_data <= '0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        m_tready    <= 1'b1;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset length of the delay unit
        issue_command(CMD_START, 8'h00, 2, 1'b1);
        issue_command(CMD_STOP, 8'h00, 2, 1'b1);

        // zero unit length, every command, byte extremes, ack and nack
        set_unit(16'd0);
        issue_command(CMD_START, 8'h00, 2, 1'b1);
        issue_command(CMD_READ, 8'h00, 2, 1'b1);
        issue_command(CMD_ACK, 8'h00, 2, 1'b1);
        issue_command(CMD_WRITE, 8'hFF, 2, 1'b1);
        issue_command(CMD_WACK, 8'h00, 0, 1'b1);
        issue_command(CMD_WRITE, 8'h00, 2, 1'b1);
        issue_command(CMD_WACK, 8'hFF, 1, 1'b1);
        issue_command(CMD_WRITE, 8'hA5, 2, 1'b1);
        issue_command(CMD_READ, 8'h00, 1, 1'b1);
        issue_command(CMD_READ, 8'hFF, 0, 1'b1);
        issue_command(CMD_NACK, 8'h00, 2, 1'b1);
        issue_command(CMD_NONE, 8'hFF, 1, 1'b1);
        issue_command(CMD_STOP, 8'h00, 2, 1'b1);

        set_unit(16'd1);
        run_random(550);
        set_unit(16'd2);
        run_random(350);
        set_unit(16'($urandom_range(3, 6)));
        run_random(300);
        set_unit(16'd0);
        run_random(200);

        // widest delay unit: start a stop and tick partway into its first unit
        set_unit(16'hFFFF);
        send_tick(CMD_STOP, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        repeat (40)
            send_tick(cmd_t'($urandom_range(0, 7)), 8'($urandom_range(0, 255)),
                      1'($urandom_range(0, 1)));

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);
        sb.errors += sb.pending();

        $display("Covered %0d ticks, %0d commands started and %0d completed,",
                 sb.ticks, sb.cmds_started, sb.cmds_done);
        $display("over %0d delay unit settings from zero to 65535.", unit_settings);
        if (sb.errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
